// ===== rtl/i2c_mras_pkg.sv =====
// Shared types and codes for the I2C master register access sequencer.
package i2c_mras_pkg;

    typedef enum logic [2:0] {
        ST_START      = 3'd0,
        ST_RSTART     = 3'd1,
        ST_ADDR_ACK   = 3'd2,
        ST_ADDR_NACK  = 3'd3,
        ST_DATA_ACK   = 3'd4,
        ST_DATA_NACK  = 3'd5,
        ST_ARB_LOST   = 3'd6,
        ST_OTHER      = 3'd7
    } bus_status_t;

    typedef enum logic [2:0] {
        ACT_START  = 3'd0,
        ACT_SEND   = 3'd1,
        ACT_RXACK  = 3'd2,
        ACT_RXNACK = 3'd3,
        ACT_STOP   = 3'd4,
        ACT_NONE   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        OC_OK    = 2'd0,
        OC_NACK  = 2'd1,
        OC_ERR   = 2'd2,
        OC_RETRY = 2'd3
    } outcome_t;

    typedef enum logic [7:0] {
        PH_IDLE   = 8'b0000_0001,
        PH_START  = 8'b0000_0010,
        PH_SLAW   = 8'b0000_0100,
        PH_REG    = 8'b0000_1000,
        PH_WDATA  = 8'b0001_0000,
        PH_RSTART = 8'b0010_0000,
        PH_SLAR   = 8'b0100_0000,
        PH_RDATA  = 8'b1000_0000
    } phase_t;

    localparam logic       CMD_BEGIN       = 1'b0;
    localparam logic [7:0] MAX_RETRIES_RST = 8'd200;

    // One result beat.
    typedef struct packed {
        action_t    action;
        logic [7:0] out_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        outcome_t   outcome;
        logic [7:0] byte_count;
    } result_t;

endpackage

// ===== rtl/i2c_master_register_access_sequencer_unit.sv =====
// Top level: I2C master register read/write sequencer with registered result and skid stage.
// A result beat is registered into the output register, or into the skid register while m_ stalls.
// Throughput: one input beat per cycle while s_tready is high; every beat yields exactly one result beat.
// Output register plus skid register: s_tready drops only when both hold a beat.
// Reset (aresetn low, synchronous): phase idle, counters and target cleared,
// max_retries back to 200, result buffer emptied.
module i2c_master_register_access_sequencer_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration: max_retries
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    // input beat
    input  logic        s_tvalid,
    output logic        s_tready,
    // is_read[0], dev_addr[7:1], reg_byte[15:8], length[23:16],
    // bus_status[26:24], tx_byte[34:27], rx_byte[42:35], zero[47:43]
    input  logic [47:0] s_tdata,
    // cmd[0]
    input  logic        s_tuser,
    // result beat
    output logic        m_tvalid,
    input  logic        m_tready,
    // action[2:0], out_byte[10:3], read_byte[18:11], outcome[20:19],
    // byte_count[28:21], zero[31:29]
    output logic [31:0] m_tdata,
    // read_valid[0]
    output logic        m_tuser,
    // done_res
    output logic        m_tlast
);
    import i2c_mras_pkg::*;

    // input field split
    logic        in_is_read;
    logic [6:0]  in_dev_addr;
    logic [7:0]  in_reg_byte;
    logic [7:0]  in_length;
    bus_status_t in_status;
    logic [7:0]  in_tx_byte;
    logic [7:0]  in_rx_byte;

    assign in_is_read    = s_tdata[0];
    assign in_dev_addr   = s_tdata[7:1];
    assign in_reg_byte   = s_tdata[15:8];
    assign in_length     = s_tdata[23:16];
    assign in_status     = bus_status_t'(s_tdata[26:24]);
    assign in_tx_byte    = s_tdata[34:27];
    assign in_rx_byte    = s_tdata[42:35];

    // transaction state
    phase_t     phase_reg,       phase_next;
    logic [7:0] retry_count_reg, retry_count_next;
    logic [7:0] bytes_left_reg,  bytes_left_next;
    logic [7:0] bytes_done_reg,  bytes_done_next;
    logic       read_mode_reg,   read_mode_next;
    logic [6:0] target_addr_reg, target_addr_next;
    logic [7:0] target_reg_reg,  target_reg_next;
    logic [7:0] max_retries_reg;

    // result buffer
    result_t out_reg, skid_reg, res;
    logic    out_valid_reg, skid_valid_reg;
    logic    accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;

    always_comb begin
        logic [7:0] bl;
        logic [7:0] bd;
        logic       fin;
        action_t    fin_act;
        outcome_t   fin_oc;

        phase_next       = phase_reg;
        retry_count_next = retry_count_reg;
        bytes_left_next  = bytes_left_reg;
        bytes_done_next  = bytes_done_reg;
        read_mode_next   = read_mode_reg;
        target_addr_next = target_addr_reg;
        target_reg_next  = target_reg_reg;

        res            = '0;
        res.action     = ACT_NONE;
        res.outcome    = OC_OK;
        fin            = 1'b0;
        fin_act        = ACT_STOP;
        fin_oc         = OC_ERR;
        bl             = bytes_left_reg;
        bd             = bytes_done_reg;

        if (s_tuser == CMD_BEGIN) begin
            read_mode_next   = in_is_read;
            target_addr_next = in_dev_addr;
            target_reg_next  = in_reg_byte;
            bl               = in_length;
            bd               = '0;
            retry_count_next = '0;
            if (max_retries_reg == '0) begin
                fin     = 1'b1;
                fin_act = ACT_NONE;
                fin_oc  = OC_RETRY;
            end else begin
                retry_count_next = 8'd1;
                res.action       = ACT_START;
                phase_next       = PH_START;
            end
        end else begin
            case (phase_reg)
                PH_IDLE: begin
                    phase_next = PH_IDLE;
                end
                PH_START, PH_RSTART: begin
                    if (in_status == ST_START || in_status == ST_RSTART) begin
                        res.action = ACT_SEND;
                        if (phase_reg == PH_START) begin
                            res.out_byte = {target_addr_reg, 1'b0};
                            phase_next   = PH_SLAW;
                        end else begin
                            res.out_byte = {target_addr_reg, 1'b1};
                            phase_next   = PH_SLAR;
                        end
                    end else if (in_status == ST_ARB_LOST) begin
                        res.action = ACT_START;
                        phase_next = PH_START;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_SLAW: begin
                    if (in_status == ST_ADDR_ACK) begin
                        res.action   = ACT_SEND;
                        res.out_byte = target_reg_reg;
                        phase_next   = PH_REG;
                    end else if (in_status == ST_ADDR_NACK) begin
                        if (retry_count_reg >= max_retries_reg) begin
                            fin    = 1'b1;
                            fin_oc = OC_RETRY;
                        end else begin
                            retry_count_next = 8'(retry_count_reg + 8'd1);
                            res.action       = ACT_START;
                            phase_next       = PH_START;
                        end
                    end else if (in_status == ST_ARB_LOST) begin
                        res.action = ACT_START;
                        phase_next = PH_START;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_REG, PH_WDATA: begin
                    if (in_status == ST_DATA_ACK) begin
                        if (phase_reg == PH_WDATA) begin
                            bd = 8'(bytes_done_reg + 8'd1);
                        end
                        if (phase_reg == PH_REG && read_mode_reg) begin
                            res.action = ACT_START;
                            phase_next = PH_RSTART;
                        end else if (bytes_left_reg == '0) begin
                            fin    = 1'b1;
                            fin_oc = OC_OK;
                        end else begin
                            bl           = 8'(bytes_left_reg - 8'd1);
                            res.action   = ACT_SEND;
                            res.out_byte = in_tx_byte;
                            phase_next   = PH_WDATA;
                        end
                    end else if (phase_reg == PH_REG && in_status == ST_DATA_NACK) begin
                        fin    = 1'b1;
                        fin_oc = OC_NACK;
                    end else if (phase_reg == PH_REG && in_status == ST_ARB_LOST) begin
                        res.action = ACT_START;
                        phase_next = PH_START;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_SLAR: begin
                    if (in_status == ST_ADDR_ACK) begin
                        if (bytes_left_reg == '0) begin
                            fin    = 1'b1;
                            fin_oc = OC_OK;
                        end else begin
                            res.action = (bytes_left_reg > 8'd1) ? ACT_RXACK : ACT_RXNACK;
                            phase_next = PH_RDATA;
                        end
                    end else if (in_status == ST_ADDR_NACK) begin
                        fin    = 1'b1;
                        fin_oc = OC_NACK;
                    end else if (in_status == ST_ARB_LOST) begin
                        res.action = ACT_START;
                        phase_next = PH_START;
                    end else begin
                        fin = 1'b1;
                    end
                end
                PH_RDATA: begin
                    if (in_status == ST_DATA_ACK || in_status == ST_DATA_NACK) begin
                        res.read_valid = 1'b1;
                        res.read_byte  = in_rx_byte;
                        bd             = 8'(bytes_done_reg + 8'd1);
                        if (bytes_left_reg != '0) begin
                            bl = 8'(bytes_left_reg - 8'd1);
                        end
                        if (bl == '0) begin
                            fin    = 1'b1;
                            fin_oc = OC_OK;
                        end else if (in_status == ST_DATA_NACK) begin
                            fin    = 1'b1;
                            fin_oc = OC_NACK;
                        end else begin
                            res.action = (bl > 8'd1) ? ACT_RXACK : ACT_RXNACK;
                            phase_next = PH_RDATA;
                        end
                    end else begin
                        fin = 1'b1;
                    end
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        if (fin) begin
            res.action     = fin_act;
            res.done_res   = 1'b1;
            res.outcome    = fin_oc;
            res.byte_count = bd;
            phase_next     = PH_IDLE;
        end

        bytes_left_next = bl;
        bytes_done_next = bd;
    end

    // state and config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            retry_count_reg <= '0;
            bytes_left_reg  <= '0;
            bytes_done_reg  <= '0;
            read_mode_reg   <= 1'b0;
            target_addr_reg <= '0;
            target_reg_reg  <= '0;
            max_retries_reg <= MAX_RETRIES_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_retries_reg <= cfg_data;
            end
            if (accept) begin
                phase_reg       <= phase_next;
                retry_count_reg <= retry_count_next;
                bytes_left_reg  <= bytes_left_next;
                bytes_done_reg  <= bytes_done_next;
                read_mode_reg   <= read_mode_next;
                target_addr_reg <= target_addr_next;
                target_reg_reg  <= target_reg_next;
            end
        end
    end

    // result buffer: output register fed from skid first, skid fills on stall
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_tready || !out_valid_reg) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !out_valid_reg) begin
            out_reg <= skid_valid_reg ? skid_reg : res;
        end else if (accept) begin
            skid_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_reg.byte_count, out_reg.outcome, out_reg.read_byte,
                       out_reg.out_byte, out_reg.action};
    assign m_tuser  = out_reg.read_valid;
    assign m_tlast  = out_reg.done_res;

`ifndef ASSERT_OFF
    // skid only ever holds a beat behind a full output register
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while output register is empty");

    // a begin with a zero retry limit leaves the sequencer idle
    a_zero_limit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == CMD_BEGIN && max_retries_reg == '0 && !cfg_valid)
        |=> phase_reg == PH_IDLE)
        else $error("zero retry limit did not end the transaction");

    // a begin with a nonzero limit counts the first attempt and asks for START
    a_begin_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == CMD_BEGIN && max_retries_reg != '0)
        |=> (phase_reg == PH_START && retry_count_reg == 8'd1))
        else $error("begin did not arm the first attempt");

    // a stalled result stays put while the skid catches the next beat
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_reg)))
        else $error("stalled result changed");
`endif

endmodule
